// File: design/alpb_pkg.sv
// ----------------------------------------------------------------------------
// alpb_pkg
// Shared types and constants for the antialiased line pixel blend.
// ----------------------------------------------------------------------------
package alpb_pkg;

    localparam int C_CANVAS_DIM  = 1024;
    localparam int C_QUEUE_DEPTH = 4;

    localparam int C_NUM_W   = 51;
    localparam int C_DEN_W   = 30;
    localparam int C_DIST_W  = 37;
    localparam int C_ROOT_W  = 19;
    localparam int C_COV_W   = 14;
    localparam int C_RAMP_Q_W = 14;

    localparam logic [1:0] C_CLS_ZERO = 2'd0;
    localparam logic [1:0] C_CLS_FULL = 2'd1;
    localparam logic [1:0] C_CLS_RAMP = 2'd2;

    localparam logic [C_COV_W-1:0] C_COV_ONE    = 14'd8192;
    localparam logic [20:0]        C_BLEND_DEN  = 21'd2088960;
    localparam logic [20:0]        C_BLEND_HALF = 21'd1044480;
    localparam logic [15:0]        C_RECIP_255  = 16'h8081;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [7:0]  canvas_red;
        logic [7:0]  canvas_green;
        logic [7:0]  canvas_blue;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] blended_red;
        logic [7:0] blended_green;
        logic [7:0] blended_blue;
        logic       was_covered;
    } t_pixel_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [13:0] sx;
        logic [13:0] sy;
        logic [13:0] ex;
        logic [13:0] ey;
    } t_seg;

    typedef struct packed {
        logic signed [14:0] vx;
        logic signed [14:0] vy;
        logic [29:0]        v2;
        logic [20:0]        ou2;
        logic [19:0]        in2;
        logic [10:0]        outr;
        logic               thick;
    } t_geom;

    typedef struct packed {
        logic [1:0]         cls;
        logic [C_NUM_W-1:0] num;
        logic [C_DEN_W-1:0] den;
        t_rgb               rgb;
    } t_work;

endpackage

// File: design/antialiased_line_pixel_blend.sv
// ----------------------------------------------------------------------------
// antialiased_line_pixel_blend
// Blends an antialiased thick line segment into a stream of canvas pixels.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Word moved
//  pixel    start, busy, i_pixel             one pixel position and colour
//  result   o_result_valid, o_result         one blended pixel colour
//  config   psel, penable, pwrite, paddr...  one 32-bit register word
//
// One pixel is accepted per cycle while busy is low. The latency is set by the
// bit-per-stage distance divider, square root and ramp divider pipelines.
// Reset is synchronous and active low; it clears all valid flags and loads the
// register defaults. Busy rises only if the queue between the halves fills,
// which cannot happen since results are never held.
module antialiased_line_pixel_blend #(
    parameter int QUEUE_DEPTH = alpb_pkg::C_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  alpb_pkg::t_pixel_in  i_pixel,
    output logic                 o_result_valid,
    output alpb_pkg::t_pixel_out o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import alpb_pkg::*;

    localparam logic [2:0] C_REG_START_X = 3'd0;
    localparam logic [2:0] C_REG_START_Y = 3'd1;
    localparam logic [2:0] C_REG_END_X   = 3'd2;
    localparam logic [2:0] C_REG_END_Y   = 3'd3;
    localparam logic [2:0] C_REG_WIDTH   = 3'd4;
    localparam logic [2:0] C_REG_OPACITY = 3'd5;
    localparam logic [2:0] C_REG_COLOR   = 3'd6;

    logic [13:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic [9:0]  r_width;
    logic [7:0]  r_opacity;
    logic [23:0] r_color;

    logic signed [14:0] r_vx, r_vy;
    logic [10:0]        r_outr;
    logic [9:0]         r_inr;
    logic               r_thick;
    t_geom              r_geom;

    logic               wr;
    logic [2:0]         idx;
    logic signed [29:0] sqx, sqy;
    t_seg               seg;

    logic  push, full, q_valid;
    t_work f_work, q_work;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= 14'd16;
            r_start_y <= 14'd16;
            r_end_x   <= 14'd16;
            r_end_y   <= 14'd16;
            r_width   <= 10'd16;
            r_opacity <= 8'd0;
            r_color   <= 24'd0;
        end else if (wr) begin
            case (idx)
                C_REG_START_X: r_start_x <= pwdata[13:0];
                C_REG_START_Y: r_start_y <= pwdata[13:0];
                C_REG_END_X:   r_end_x   <= pwdata[13:0];
                C_REG_END_Y:   r_end_y   <= pwdata[13:0];
                C_REG_WIDTH:   r_width   <= pwdata[9:0];
                C_REG_OPACITY: r_opacity <= pwdata[7:0];
                C_REG_COLOR:   r_color   <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            C_REG_START_X: prdata = {18'b0, r_start_x};
            C_REG_START_Y: prdata = {18'b0, r_start_y};
            C_REG_END_X:   prdata = {18'b0, r_end_x};
            C_REG_END_Y:   prdata = {18'b0, r_end_y};
            C_REG_WIDTH:   prdata = {22'b0, r_width};
            C_REG_OPACITY: prdata = {24'b0, r_opacity};
            C_REG_COLOR:   prdata = {8'b0, r_color};
            default:       prdata = '0;
        endcase
    end

    assign sqx = r_vx * r_vx;
    assign sqy = r_vy * r_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx    <= '0;
            r_vy    <= '0;
            r_outr  <= 11'd32;
            r_inr   <= '0;
            r_thick <= 1'b0;
            r_geom  <= '{vx: '0, vy: '0, v2: '0, ou2: 21'd1024, in2: '0,
                         outr: 11'd32, thick: 1'b0};
        end else begin
            r_vx    <= $signed({1'b0, r_end_x}) - $signed({1'b0, r_start_x});
            r_vy    <= $signed({1'b0, r_end_y}) - $signed({1'b0, r_start_y});
            r_outr  <= {1'b0, r_width} + 11'd16;
            r_inr   <= r_width - 10'd16;
            r_thick <= r_width > 10'd16;
            r_geom.vx    <= r_vx;
            r_geom.vy    <= r_vy;
            r_geom.v2    <= $unsigned(sqx) + $unsigned(sqy);
            r_geom.ou2   <= 21'(r_outr * r_outr);
            r_geom.in2   <= r_inr * r_inr;
            r_geom.outr  <= r_outr;
            r_geom.thick <= r_thick;
        end
    end

    assign seg = '{sx: r_start_x, sy: r_start_y, ex: r_end_x, ey: r_end_y};

    alpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_pixel (i_pixel),
        .i_seg   (seg),
        .i_geom  (r_geom),
        .i_full  (full),
        .o_push  (push),
        .o_work  (f_work)
    );

    alpb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (f_work),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    alpb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_work    (q_work),
        .i_geom    (r_geom),
        .i_opacity (r_opacity),
        .i_color   (r_color),
        .o_valid   (o_result_valid),
        .o_result  (o_result)
    );
endmodule

// File: design/alpb_div.sv
// ----------------------------------------------------------------------------
// alpb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module alpb_div #(
    parameter int NUM_W = 67,
    parameter int DEN_W = 30,
    parameter int Q_W   = 37
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_q
);
    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [NUM_W-1:0] r_num [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] num_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             ge;
        if (g == 0) begin : g_first
            assign rem_in = DEN_W'(i_num >> Q_W);
            assign den_in = i_den;
            assign num_in = i_num;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign num_in = r_num[g-1];
            assign q_in   = r_q[g-1];
        end
        assign shifted = {rem_in, num_in[Q_W-1-g]};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = shifted >= {1'b0, den_in};
        always_ff @(posedge i_clk) begin
            r_den[g] <= den_in;
            r_num[g] <= num_in;
            r_q[g]   <= {q_in[Q_W-2:0], ge};
            r_rem[g] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_q = r_q[Q_W-1];
endmodule

// File: design/alpb_sqrt.sv
// ----------------------------------------------------------------------------
// alpb_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module alpb_sqrt #(
    parameter int ROOT_W = 19
) (
    input  logic [2*ROOT_W-1:0] i_rad,
    input  logic                i_clk,
    output logic [ROOT_W-1:0]   o_root
);
    localparam int RW = ROOT_W + 2;

    logic [RW-1:0]       r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [2*ROOT_W-1:0] r_rad  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [RW-1:0]       rem_in;
        logic [ROOT_W-1:0]   root_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [RW+1:0]       shifted;
        logic [RW+1:0]       trial;
        logic [RW+1:0]       diff;
        logic                ge;
        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
        end
        assign shifted = {rem_in, rad_in[2*(ROOT_W-1-g)+1 -: 2]};
        assign trial   = {2'b00, root_in, 2'b01};
        assign diff    = shifted - trial;
        assign ge      = shifted >= trial;
        always_ff @(posedge i_clk) begin
            r_rad[g]  <= rad_in;
            r_root[g] <= {root_in[ROOT_W-2:0], ge};
            r_rem[g]  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

// File: design/alpb_front.sv
// ----------------------------------------------------------------------------
// alpb_front
// Projects each pixel onto the segment and classifies its coverage band.
// ----------------------------------------------------------------------------
module alpb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  alpb_pkg::t_pixel_in   i_pixel,
    input  alpb_pkg::t_seg        i_seg,
    input  alpb_pkg::t_geom       i_geom,
    input  logic                  i_full,
    output logic                  o_push,
    output alpb_pkg::t_work       o_work
);
    import alpb_pkg::*;

    logic en;
    logic [7:0] r_v;

    logic        r1_in;
    logic [15:0] r1_px, r1_py;
    t_rgb        r_rgb [8];
    logic        r_in  [2:7];

    logic signed [16:0] r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [31:0] r3_pax, r3_pay;
    logic [29:0]        r3_sax, r3_say, r3_sbx, r3_sby;
    logic signed [32:0] r4_dot;
    logic [30:0]        r4_a2, r4_b2;
    logic               r5_ea, r5_eb;
    logic [30:0]        r5_a2, r5_b2;
    logic [60:0]        r5_p1;
    logic [59:0]        r5_p2;
    logic [62:0]        r6_num, r7_num;
    logic [29:0]        r6_den, r7_den;
    logic [50:0]        r7_po;
    logic [49:0]        r7_pi;
    logic [1:0]         r8_cls;
    logic [50:0]        r8_num;
    logic [29:0]        r8_den;

    logic               n1_in;
    logic signed [33:0] n3_sax, n3_say, n3_sbx, n3_sby;
    logic [60:0]        n6_diff;
    logic [1:0]         n8_cls;

    assign o_busy = r_v[7] && i_full;
    assign en     = !o_busy;
    assign o_push = r_v[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[6:0], i_start};
        end
    end

    assign n1_in = (i_pixel.pixel_x != 11'd0) && (i_pixel.pixel_y != 11'd0)
        && ({2'b00, i_pixel.pixel_x} <= 13'(C_CANVAS_DIM))
        && ({2'b00, i_pixel.pixel_y} <= 13'(C_CANVAS_DIM));

    assign n3_sax = r2_ax * r2_ax;
    assign n3_say = r2_ay * r2_ay;
    assign n3_sbx = r2_bx * r2_bx;
    assign n3_sby = r2_by * r2_by;

    assign n6_diff = r5_p1 - {1'b0, r5_p2};

    always_comb begin
        if (!r_in[7] || (r7_num >= {12'b0, r7_po})) begin
            n8_cls = C_CLS_ZERO;
        end else if (i_geom.thick && (r7_num <= {13'b0, r7_pi})) begin
            n8_cls = C_CLS_FULL;
        end else begin
            n8_cls = C_CLS_RAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rgb[0] <= {i_pixel.canvas_red, i_pixel.canvas_green, i_pixel.canvas_blue};
            for (int k = 1; k < 8; k++) begin
                r_rgb[k] <= r_rgb[k-1];
            end
            r1_in <= n1_in;
            r_in[2] <= r1_in;
            for (int k = 3; k <= 7; k++) begin
                r_in[k] <= r_in[k-1];
            end
            r1_px <= 16'({i_pixel.pixel_x, 4'b0000}) - 16'd8;
            r1_py <= 16'({i_pixel.pixel_y, 4'b0000}) - 16'd8;

            r2_ax <= $signed({1'b0, r1_px}) - $signed({3'b000, i_seg.sx});
            r2_ay <= $signed({1'b0, r1_py}) - $signed({3'b000, i_seg.sy});
            r2_bx <= $signed({1'b0, r1_px}) - $signed({3'b000, i_seg.ex});
            r2_by <= $signed({1'b0, r1_py}) - $signed({3'b000, i_seg.ey});

            r3_pax <= r2_ax * i_geom.vx;
            r3_pay <= r2_ay * i_geom.vy;
            r3_sax <= n3_sax[29:0];
            r3_say <= n3_say[29:0];
            r3_sbx <= n3_sbx[29:0];
            r3_sby <= n3_sby[29:0];

            r4_dot <= {r3_pax[31], r3_pax} + {r3_pay[31], r3_pay};
            r4_a2  <= {1'b0, r3_sax} + {1'b0, r3_say};
            r4_b2  <= {1'b0, r3_sbx} + {1'b0, r3_sby};

            r5_ea <= (i_geom.v2 == 30'd0) || r4_dot[32] || (r4_dot == 33'sd0);
            r5_eb <= !r4_dot[32] && (r4_dot[31:0] >= {2'b00, i_geom.v2});
            r5_a2 <= r4_a2;
            r5_b2 <= r4_b2;
            r5_p1 <= r4_a2 * i_geom.v2;
            r5_p2 <= r4_dot[29:0] * r4_dot[29:0];

            if (r5_ea) begin
                r6_num <= {30'b0, r5_a2, 2'b00};
                r6_den <= 30'd1;
            end else if (r5_eb) begin
                r6_num <= {30'b0, r5_b2, 2'b00};
                r6_den <= 30'd1;
            end else begin
                r6_num <= {n6_diff, 2'b00};
                r6_den <= i_geom.v2;
            end

            r7_num <= r6_num;
            r7_den <= r6_den;
            r7_po  <= i_geom.ou2 * r6_den;
            r7_pi  <= i_geom.in2 * r6_den;

            r8_cls <= n8_cls;
            r8_num <= r7_num[50:0];
            r8_den <= r7_den;
        end
    end

    assign o_work = '{cls: r8_cls, num: r8_num, den: r8_den, rgb: r_rgb[7]};
endmodule

// File: design/alpb_queue.sv
// ----------------------------------------------------------------------------
// alpb_queue
// Short first-in first-out queue between the front and back halves.
// ----------------------------------------------------------------------------
module alpb_queue #(
    parameter int DEPTH = alpb_pkg::C_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  alpb_pkg::t_work i_data,
    output logic            o_full,
    output logic            o_valid,
    output alpb_pkg::t_work o_data
);
    import alpb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             r_valid;
    t_work            r_data;
    logic             pop;

    assign pop    = r_count != '0;
    assign o_full = r_count == CNT_W'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= pop;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (pop) begin
            r_data <= r_mem[r_rptr];
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: design/alpb_back.sv
// ----------------------------------------------------------------------------
// alpb_back
// Distance, coverage ramp and alpha blend for classified pixels.
// ----------------------------------------------------------------------------
module alpb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  alpb_pkg::t_work      i_work,
    input  alpb_pkg::t_geom      i_geom,
    input  logic [7:0]           i_opacity,
    input  alpb_pkg::t_rgb       i_color,
    output logic                 o_valid,
    output alpb_pkg::t_pixel_out o_result
);
    import alpb_pkg::*;

    localparam int L1 = C_DIST_W + C_ROOT_W;
    localparam int L2 = C_RAMP_Q_W;

    typedef struct packed {
        logic [1:0] cls;
        t_rgb       rgb;
    } t_side;

    typedef struct packed {
        logic [1:0]         cls;
        t_rgb               rgb;
        logic               lt;
        logic [C_COV_W-1:0] covt;
    } t_side2;

    logic [L1-1:0] r_sv;
    t_side         r_sp [L1];
    logic [L2-1:0] r_s2v;
    t_side2        r_s2p [L2];

    logic [C_DIST_W-1:0]   q;
    logic [C_ROOT_W-1:0]   d;
    logic [C_ROOT_W-1:0]   o_rad;
    logic [C_ROOT_W-1:0]   od;
    logic [C_RAMP_Q_W-1:0] q2;

    logic         r_c1_v;
    t_side2       r_c1;
    logic [23:0]  r_c1_dvd;

    logic               r_c2_v;
    logic [C_COV_W-1:0] r_c2_cov;
    t_rgb               r_c2_rgb;
    logic [C_COV_W-1:0] n_c2_cov;

    logic [4:0]  r_bv;
    t_rgb        r_brgb [4];
    logic        r_bcvd [4];
    logic [20:0] r_b1_a;
    logic [28:0] r_b2_pin [3];
    logic [28:0] r_b2_pln [3];
    logic [15:0] r_b3_y   [3];
    logic [31:0] r_b4_z   [3];
    t_pixel_out  r_out;

    logic [7:0]  cin   [3];
    logic [7:0]  cln   [3];
    logic [7:0]  cold  [3];
    logic [20:0] inv_a;
    logic [28:0] sum   [3];

    alpb_div #(.NUM_W(C_NUM_W + 16), .DEN_W(C_DEN_W), .Q_W(C_DIST_W)) u_div_dist (
        .i_clk (i_clk),
        .i_num ({i_work.num, 16'b0}),
        .i_den (i_work.den),
        .o_q   (q)
    );

    alpb_sqrt #(.ROOT_W(C_ROOT_W)) u_sqrt (
        .i_rad  ({1'b0, q}),
        .i_clk  (i_clk),
        .o_root (d)
    );

    alpb_div #(.NUM_W(24), .DEN_W(11), .Q_W(C_RAMP_Q_W)) u_div_ramp (
        .i_clk (i_clk),
        .i_num (r_c1_dvd),
        .i_den (i_geom.outr),
        .o_q   (q2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= '0;
            r_c1_v <= 1'b0;
            r_s2v  <= '0;
            r_c2_v <= 1'b0;
            r_bv   <= '0;
        end else begin
            r_sv   <= {r_sv[L1-2:0], i_valid};
            r_c1_v <= r_sv[L1-1];
            r_s2v  <= {r_s2v[L2-2:0], r_c1_v};
            r_c2_v <= r_s2v[L2-1];
            r_bv   <= {r_bv[3:0], r_c2_v};
        end
    end

    assign o_rad = {i_geom.outr, 8'b0};
    assign od    = o_rad - d;

    always_comb begin
        if (r_s2p[L2-1].cls == C_CLS_ZERO) begin
            n_c2_cov = '0;
        end else if (r_s2p[L2-1].cls == C_CLS_FULL) begin
            n_c2_cov = C_COV_ONE;
        end else if (i_geom.thick) begin
            n_c2_cov = r_s2p[L2-1].covt;
        end else if (r_s2p[L2-1].lt) begin
            n_c2_cov = q2;
        end else begin
            n_c2_cov = '0;
        end
    end

    assign cin[0] = r_brgb[0].red;
    assign cin[1] = r_brgb[0].green;
    assign cin[2] = r_brgb[0].blue;
    assign cln[0] = i_color.red;
    assign cln[1] = i_color.green;
    assign cln[2] = i_color.blue;
    assign cold[0] = r_brgb[3].red;
    assign cold[1] = r_brgb[3].green;
    assign cold[2] = r_brgb[3].blue;
    assign inv_a  = C_BLEND_DEN - r_b1_a;

    for (genvar c = 0; c < 3; c++) begin : g_sum
        assign sum[c] = r_b2_pin[c] + r_b2_pln[c] + {8'b0, C_BLEND_HALF};
    end

    always_ff @(posedge i_clk) begin
        r_sp[0] <= '{cls: i_work.cls, rgb: i_work.rgb};
        for (int k = 1; k < L1; k++) begin
            r_sp[k] <= r_sp[k-1];
        end

        r_c1.cls  <= r_sp[L1-1].cls;
        r_c1.rgb  <= r_sp[L1-1].rgb;
        r_c1.lt   <= d < o_rad;
        if (d >= o_rad) begin
            r_c1.covt <= '0;
        end else if (od > {5'b0, C_COV_ONE}) begin
            r_c1.covt <= C_COV_ONE;
        end else begin
            r_c1.covt <= od[C_COV_W-1:0];
        end
        r_c1_dvd <= {od, 5'b0};

        r_s2p[0] <= r_c1;
        for (int k = 1; k < L2; k++) begin
            r_s2p[k] <= r_s2p[k-1];
        end

        r_c2_cov <= n_c2_cov;
        r_c2_rgb <= r_s2p[L2-1].rgb;

        r_b1_a    <= 21'(r_c2_cov * i_opacity);
        r_bcvd[0] <= (r_c2_cov != '0) && (i_opacity != 8'd0);
        r_brgb[0] <= r_c2_rgb;
        for (int k = 1; k < 4; k++) begin
            r_bcvd[k] <= r_bcvd[k-1];
            r_brgb[k] <= r_brgb[k-1];
        end

        for (int c = 0; c < 3; c++) begin
            r_b2_pin[c] <= cin[c] * inv_a;
            r_b2_pln[c] <= cln[c] * r_b1_a;
            r_b3_y[c]   <= sum[c][28:13];
            r_b4_z[c]   <= r_b3_y[c] * C_RECIP_255;
        end

        r_out.blended_red   <= r_bcvd[3] ? r_b4_z[0][30:23] : cold[0];
        r_out.blended_green <= r_bcvd[3] ? r_b4_z[1][30:23] : cold[1];
        r_out.blended_blue  <= r_bcvd[3] ? r_b4_z[2][30:23] : cold[2];
        r_out.was_covered   <= r_bcvd[3];
    end

    assign o_valid  = r_bv[4];
    assign o_result = r_out;
endmodule

// File: sim/alpb_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpb_tb_pkg
// Register map of the line blend configuration port, shared by the bench.
// ----------------------------------------------------------------------------
package alpb_tb_pkg;

    typedef enum int {
        REG_START_X      = 0,
        REG_START_Y      = 1,
        REG_END_X        = 2,
        REG_END_Y        = 3,
        REG_STROKE_WIDTH = 4,
        REG_OPACITY      = 5,
        REG_STROKE_COLOR = 6
    } t_reg_index;

endpackage

// File: sim/alpb_blend_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpb_blend_checker
// Watches the pixel, result and register channels of the line blend, predicts
// each blended pixel from its own copy of the registers and compares results
// in order against the predicted words.
// ----------------------------------------------------------------------------
module alpb_blend_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  alpb_pkg::t_pixel_in  i_pixel,
    input  logic                 o_result_valid,
    input  alpb_pkg::t_pixel_out o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pending
);
    import alpb_pkg::*;
    import alpb_tb_pkg::*;

    localparam longint unsigned BLEND_M = 64'd8192 * 64'd255;

    logic [13:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [9:0]  line_width;
    logic [7:0]  line_opacity;
    logic [23:0] line_rgb;
    t_pixel_out  blend_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] mix_chan(longint unsigned c, longint unsigned l,
                                            longint unsigned a);
        longint unsigned q;
        q = (c * (BLEND_M - a) + l * a + BLEND_M / 2) / BLEND_M;
        return q[7:0];
    endfunction

    function automatic t_pixel_out predict_blend(t_pixel_in p);
        t_pixel_out      r;
        longint          px, py, ax, ay, vx, vy, v2, dp, bx, by;
        longint unsigned num, den, w, outr, cov, qi, rem, q, d, o, a;
        r.blended_red   = p.canvas_red;
        r.blended_green = p.canvas_green;
        r.blended_blue  = p.canvas_blue;
        r.was_covered   = 1'b0;
        if (p.pixel_x < 1 || p.pixel_x > C_CANVAS_DIM || p.pixel_y < 1 ||
            p.pixel_y > C_CANVAS_DIM) return r;
        px = longint'(p.pixel_x) * 16 - 8;
        py = longint'(p.pixel_y) * 16 - 8;
        ax = px - longint'(seg_sx);
        ay = py - longint'(seg_sy);
        vx = longint'(seg_ex) - longint'(seg_sx);
        vy = longint'(seg_ey) - longint'(seg_sy);
        v2 = vx * vx + vy * vy;
        dp = ax * vx + ay * vy;
        w = line_width;
        outr = w + 16;
        if (v2 == 0 || dp <= 0) begin
            num = ax * ax + ay * ay;
            den = 1;
        end else if (dp >= v2) begin
            bx = px - longint'(seg_ex);
            by = py - longint'(seg_ey);
            num = bx * bx + by * by;
            den = 1;
        end else begin
            num = longint'(ax * ax + ay * ay) * v2 - dp * dp;
            den = v2;
        end
        num = num * 4;
        cov = 0;
        if (num >= outr * outr * den) begin
            cov = 0;
        end else if (w > 16 && num <= (w - 16) * (w - 16) * den) begin
            cov = 8192;
        end else begin
            qi = num / den;
            rem = num % den;
            q = (qi << 16) + (rem << 16) / den;
            d = int_sqrt(q);
            o = outr * 256;
            if (d >= o) cov = 0;
            else if (w <= 16) cov = (o - d) * 8192 / o;
            else cov = o - d;
            if (cov > 8192) cov = 8192;
        end
        if (cov == 0 || line_opacity == 0) return r;
        a = cov * line_opacity;
        r.blended_red   = mix_chan(p.canvas_red, line_rgb[23:16], a);
        r.blended_green = mix_chan(p.canvas_green, line_rgb[15:8], a);
        r.blended_blue  = mix_chan(p.canvas_blue, line_rgb[7:0], a);
        r.was_covered   = 1'b1;
        return r;
    endfunction

    assign o_pending = blend_queue.size();

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (!i_rst_n) begin
            seg_sx <= 14'd16;
            seg_sy <= 14'd16;
            seg_ex <= 14'd16;
            seg_ey <= 14'd16;
            line_width <= 10'd16;
            line_opacity <= 8'd0;
            line_rgb <= 24'd0;
            o_fail_count <= 0;
            blend_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (int'(paddr >> 2))
                    REG_START_X:      seg_sx <= pwdata[13:0];
                    REG_START_Y:      seg_sy <= pwdata[13:0];
                    REG_END_X:        seg_ex <= pwdata[13:0];
                    REG_END_Y:        seg_ey <= pwdata[13:0];
                    REG_STROKE_WIDTH: line_width <= pwdata[9:0];
                    REG_OPACITY:      line_opacity <= pwdata[7:0];
                    REG_STROKE_COLOR: line_rgb <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (o_result_valid) begin
                if (blend_queue.size() == 0) begin
                    $display("%0t: result word with none expected: %p", $time, o_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = blend_queue.pop_front();
                    if (want !== o_result) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) blend_queue = {blend_queue, predict_blend(i_pixel)};
        end
    end

endmodule

// File: sim/tb_antialiased_line_pixel_blend.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_antialiased_line_pixel_blend
// Drives directed and random pixels through the line blend under a series of
// segment, width, opacity and color settings with varied input gaps; the
// checker compares every result word against its own prediction.
// ----------------------------------------------------------------------------
module tb_antialiased_line_pixel_blend;
    import alpb_pkg::*;
    import alpb_tb_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_pixel_in   i_pixel = '0;
    logic        o_result_valid;
    t_pixel_out  o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          quiet_cycles = 0;
    logic [13:0] cur_sx = 14'd16, cur_sy = 14'd16, cur_ex = 14'd16, cur_ey = 14'd16;
    logic [9:0]  cur_w = 10'd16;

    antialiased_line_pixel_blend dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_pixel(i_pixel),
        .o_result_valid(o_result_valid), .o_result(o_result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    alpb_blend_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_pixel(i_pixel),
        .o_result_valid(o_result_valid), .o_result(o_result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .pready(pready), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(t_reg_index idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_line(logic [13:0] sx, logic [13:0] sy, logic [13:0] ex,
                            logic [13:0] ey, logic [9:0] w, logic [7:0] op,
                            logic [23:0] rgb);
        drain_results();
        write_reg(REG_START_X, 32'(sx));
        write_reg(REG_START_Y, 32'(sy));
        write_reg(REG_END_X, 32'(ex));
        write_reg(REG_END_Y, 32'(ey));
        write_reg(REG_STROKE_WIDTH, 32'(w));
        write_reg(REG_OPACITY, 32'(op));
        write_reg(REG_STROKE_COLOR, 32'(rgb));
        cur_sx = sx; cur_sy = sy; cur_ex = ex; cur_ey = ey; cur_w = w;
    endtask

    task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        i_pixel <= '{pixel_x: x, pixel_y: y, canvas_red: r, canvas_green: g,
                     canvas_blue: b};
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] near_coord(logic [13:0] a, logic [13:0] b, int t,
                                               int spread);
        int c;
        c = (int'(a) + (int'(b) - int'(a)) * t / 16 + 8) / 16
            + $urandom_range(0, 2 * spread) - spread;
        if (c < 1) c = 1;
        if (c > C_CANVAS_DIM) c = C_CANVAS_DIM;
        return 11'(c);
    endfunction

    task automatic send_random_pixel();
        int t;
        int spread;
        if ($urandom_range(0, 4) == 0) begin
            send_pixel(11'($urandom), 11'($urandom), rand_chan(), rand_chan(), rand_chan());
        end else begin
            t = $urandom_range(0, 24) - 4;
            spread = int'(cur_w) / 32 + 2;
            send_pixel(near_coord(cur_sx, cur_ex, t, spread),
                       near_coord(cur_sy, cur_ey, t, spread),
                       rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    task automatic random_line();
        logic [13:0] sx, sy, ex, ey;
        logic [9:0]  w;
        logic [7:0]  op;
        logic [23:0] rgb;
        int          span;
        sx = 14'($urandom);
        sy = 14'($urandom);
        case ($urandom_range(0, 3))
            0: begin ex = sx; ey = sy; end
            1: begin ex = 14'($urandom); ey = 14'($urandom); end
            default: begin
                span = $urandom_range(0, 800);
                ex = 14'(int'(sx) + $urandom_range(0, 2 * span) - span);
                ey = 14'(int'(sy) + $urandom_range(0, 2 * span) - span);
            end
        endcase
        case ($urandom_range(0, 7))
            0: w = 10'd0;
            1: w = 10'd16;
            2: w = 10'd17;
            3: w = 10'd1023;
            4: w = 10'($urandom_range(0, 15));
            default: w = 10'($urandom_range(17, 200));
        endcase
        case ($urandom_range(0, 7))
            0: op = 8'd0;
            1, 2: op = 8'd255;
            default: op = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: rgb = 24'h000000;
            1: rgb = 24'hFFFFFF;
            default: rgb = 24'($urandom);
        endcase
        set_line(sx, sy, ex, ey, w, op, rgb);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opacity is zero after reset, so these pass straight through.
        send_pixel(11'd1, 11'd1, 8'd12, 8'd34, 8'd56);
        send_pixel(11'd2, 11'd1, 8'd255, 8'd0, 8'd255);

        // Horizontal thick segment from (100,100) to (200,100).
        set_line(14'd1600, 14'd1600, 14'd3200, 14'd1600, 10'd64, 8'd255, 24'hFF8000);
        send_pixel(11'd150, 11'd101, 8'd0, 8'd0, 8'd0);
        send_pixel(11'd150, 11'd103, 8'd255, 8'd255, 8'd255);
        send_pixel(11'd150, 11'd104, 8'd10, 8'd20, 8'd30);
        send_pixel(11'd150, 11'd500, 8'd10, 8'd20, 8'd30);
        send_pixel(11'd99, 11'd100, 8'd77, 8'd88, 8'd99);
        send_pixel(11'd97, 11'd101, 8'd77, 8'd88, 8'd99);
        send_pixel(11'd203, 11'd101, 8'd1, 8'd2, 8'd3);
        send_pixel(11'd0, 11'd101, 8'd5, 8'd6, 8'd7);
        send_pixel(11'd1025, 11'd101, 8'd5, 8'd6, 8'd7);
        send_pixel(11'd150, 11'd2047, 8'd5, 8'd6, 8'd7);
        send_pixel(11'd150, 11'd0, 8'd5, 8'd6, 8'd7);

        // Zero-length segment with a thin soft ramp at the canvas corner.
        set_line(14'd16376, 14'd16376, 14'd16376, 14'd16376, 10'd0, 8'd128, 24'h00FF00);
        send_pixel(11'd1024, 11'd1024, 8'd255, 8'd0, 8'd255);
        send_pixel(11'd1023, 11'd1024, 8'd255, 8'd0, 8'd255);
        send_pixel(11'd1024, 11'd1023, 8'd0, 8'd0, 8'd0);

        // Widest stroke on a diagonal.
        set_line(14'd0, 14'd0, 14'd16383, 14'd16383, 10'd1023, 8'd1, 24'hFFFFFF);
        send_pixel(11'd1, 11'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(11'd512, 11'd540, 8'd100, 8'd100, 8'd100);
        send_pixel(11'd1024, 11'd1, 8'd200, 8'd50, 8'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: idle_pct = 88;
                2: idle_pct = 25;
                default: idle_pct = 0;
            endcase
            for (int block = 0; block < 4; block++) begin
                random_line();
                for (int n = 0; n < 60; n++) send_random_pixel();
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b0;
        drain_results();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
